// File: src/xcfr_pkg.sv
`default_nettype none
package xcfr_pkg;

  // Largest payload the receiver can hold.
  localparam int MAX_PAYLOAD = 32;
  localparam int ADDR_W      = $clog2(MAX_PAYLOAD);

  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 6;
  localparam int STATUS_W = 2;
  localparam int INDEX_W  = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 8;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_GOOD     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_SUM  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_SIZE = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER   = 1'd1;

  localparam logic [LEN_W-1:0]  PAYLOAD_LENGTH_RST = 6'd1;
  localparam logic [BYTE_W-1:0] START_MARKER_RST   = 8'd83;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                seed;        // length byte matched: seed the checksum
    logic                store;       // store a payload byte
    logic                clear;       // return counters to their hunting values
    logic                load_status; // put a status result in the output register
    logic [STATUS_W-1:0] status;
    logic                start_emit;  // read the first stored byte
    logic                emit_load;   // move the stored byte to the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic marker_hit;
    logic len_match;
    logic body_full;
    logic sum_match;
    logic emit_last;
    logic out_free;
  } stat_t;

  // Payload length clamped to the range the store supports.
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] n);
    logic [LEN_W-1:0] r;
    r = n;
    if (n == '0) r = LEN_W'(1);
    if (n > MAX_LEN) r = MAX_LEN;
    return r;
  endfunction

endpackage
`default_nettype wire

// File: src/xcfr_ram.sv
`default_nettype none
module xcfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: src/xcfr_datapath.sv
`default_nettype none
module xcfr_datapath
  import xcfr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic [BYTE_W-1:0]     in_rx_byte,
  input  wire logic                  out_ready,
  input  wire cmd_t                  cmd,
  output stat_t                      stat,
  output logic                       out_valid,
  output logic [STATUS_W-1:0]        out_status,
  output logic [BYTE_W-1:0]          out_data_byte,
  output logic [INDEX_W-1:0]         out_byte_index,
  output logic                       out_last
);

  logic [LEN_W-1:0]    payload_length_r;
  logic [BYTE_W-1:0]   start_marker_r;
  logic [LEN_W-1:0]    bytes_taken_r, bytes_taken_nxt;
  logic [BYTE_W-1:0]   running_xor_r, running_xor_nxt;
  logic [LEN_W-1:0]    rd_idx_r, rd_idx_nxt;
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [BYTE_W-1:0]   out_data_byte_r;
  logic [INDEX_W-1:0]  out_byte_index_r;
  logic                out_last_r;

  logic [LEN_W-1:0]  len;
  logic [LEN_W-1:0]  rd_idx_inc;
  logic [ADDR_W-1:0] raddr;
  logic [BYTE_W-1:0] rdata;

  assign len        = eff_len(payload_length_r);
  assign rd_idx_inc = rd_idx_r + LEN_W'(1);

  always_comb begin
    stat.marker_hit = (in_rx_byte == start_marker_r);
    stat.len_match  = (in_rx_byte == {{(BYTE_W-LEN_W){1'b0}}, len});
    stat.body_full  = (bytes_taken_r >= len);
    stat.sum_match  = (in_rx_byte == running_xor_r);
    stat.emit_last  = (rd_idx_inc == len);
    stat.out_free   = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      payload_length_r <= PAYLOAD_LENGTH_RST;
      start_marker_r   <= START_MARKER_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PAYLOAD_LENGTH: payload_length_r <= cfg_data[LEN_W-1:0];
        CFG_START_MARKER:   start_marker_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    bytes_taken_nxt = bytes_taken_r;
    running_xor_nxt = running_xor_r;
    if (cmd.clear) begin
      bytes_taken_nxt = '0;
      running_xor_nxt = '0;
    end else if (cmd.seed) begin
      bytes_taken_nxt = '0;
      running_xor_nxt = {{(BYTE_W-LEN_W){1'b0}}, len};
    end else if (cmd.store) begin
      bytes_taken_nxt = bytes_taken_r + LEN_W'(1);
      running_xor_nxt = running_xor_r ^ in_rx_byte;
    end
  end

  // The read address runs one ahead when a byte leaves, so a run streams
  // at one byte per cycle while the output register is free.
  always_comb begin
    rd_idx_nxt = rd_idx_r;
    raddr      = rd_idx_r[ADDR_W-1:0];
    if (cmd.start_emit) begin
      rd_idx_nxt = '0;
      raddr      = '0;
    end else if (cmd.emit_load) begin
      rd_idx_nxt = rd_idx_inc;
      raddr      = rd_idx_inc[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_taken_r <= '0;
      running_xor_r <= '0;
      rd_idx_r      <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      bytes_taken_r <= bytes_taken_nxt;
      running_xor_r <= running_xor_nxt;
      rd_idx_r      <= rd_idx_nxt;
      if (cmd.load_status || cmd.emit_load) out_valid_r <= 1'b1;
      else if (out_ready)                   out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_status) begin
      out_status_r     <= cmd.status;
      out_data_byte_r  <= '0;
      out_byte_index_r <= '0;
      out_last_r       <= 1'b1;
    end else if (cmd.emit_load) begin
      out_status_r     <= ST_GOOD;
      out_data_byte_r  <= rdata;
      out_byte_index_r <= rd_idx_r[INDEX_W-1:0];
      out_last_r       <= stat.emit_last;
    end
  end

  xcfr_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(MAX_PAYLOAD)
  ) u_store (
    .clk  (clk),
    .we   (cmd.store),
    .waddr(bytes_taken_r[ADDR_W-1:0]),
    .wdata(in_rx_byte),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_data_byte  = out_data_byte_r;
  assign out_byte_index = out_byte_index_r;
  assign out_last       = out_last_r;

endmodule
`default_nettype wire

// File: src/xcfr_ctrl.sv
`default_nettype none
module xcfr_ctrl
  import xcfr_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_HUNT = 4'b0001,
    S_LEN  = 4'b0010,
    S_BODY = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready = (state_r != S_EMIT) && stat.out_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_HUNT: begin
        if (accept && stat.marker_hit) state_nxt = S_LEN;
      end
      S_LEN: begin
        if (accept) begin
          if (stat.len_match) begin
            cmd.seed  = 1'b1;
            state_nxt = S_BODY;
          end else begin
            cmd.clear       = 1'b1;
            cmd.load_status = 1'b1;
            cmd.status      = ST_BAD_SIZE;
            state_nxt       = S_HUNT;
          end
        end
      end
      S_BODY: begin
        if (accept) begin
          if (!stat.body_full) begin
            cmd.store = 1'b1;
          end else if (!stat.sum_match) begin
            cmd.clear       = 1'b1;
            cmd.load_status = 1'b1;
            cmd.status      = ST_BAD_SUM;
            state_nxt       = S_HUNT;
          end else begin
            cmd.clear      = 1'b1;
            cmd.start_emit = 1'b1;
            state_nxt      = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit_load = 1'b1;
          if (stat.emit_last) state_nxt = S_HUNT;
        end
      end
      default: state_nxt = S_HUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_HUNT;
    else        state_r <= state_nxt;
  end

endmodule
`default_nettype wire

// File: src/xor_checked_frame_receiver.sv
`default_nettype none
// A status result is in the output register in the cycle after the request that causes it.
// A good frame's first byte is read from the store, then loaded when the output register is free.
// Throughput: one request per cycle while the output register is free; a good frame then holds
// input off while its L stored bytes stream out at one per cycle, as the output register allows.
// Reset (synchronous, active low) returns to hunting and restores the register defaults.
// The payload store is not cleared; it is always written before it is read.

// Framed byte receiver. Each request carries one received byte. The controller
// hunts for the start marker, checks the length byte against the configured
// payload length (clamped to 1..MAX_PAYLOAD), collects the payload into a small
// RAM while the datapath keeps a running XOR seeded with the length, and then
// compares the next byte with that XOR. A length mismatch or a checksum mismatch
// yields a single status result. A good frame replays the stored payload as a run
// of results with the last flag on the final byte.
//
// The controller and datapath talk only through the command and status structs.
// Results leave through one output register; a new request is taken whenever that
// register is empty or being drained and no payload run is streaming out. While a
// result sits unclaimed in the register, the input waits.
module xor_checked_frame_receiver
  import xcfr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [BYTE_W-1:0]     in_rx_byte,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [STATUS_W-1:0]        out_status,
  output logic [BYTE_W-1:0]          out_data_byte,
  output logic [INDEX_W-1:0]         out_byte_index,
  output logic                       out_last
);

  cmd_t  cmd;
  stat_t stat;

  // Sequencing of the frame phases.
  xcfr_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  // Configuration, counters, checksum, payload store and output register.
  xcfr_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_rx_byte    (in_rx_byte),
    .out_ready     (out_ready),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_data_byte (out_data_byte),
    .out_byte_index(out_byte_index),
    .out_last      (out_last)
  );

endmodule
`default_nettype wire

// File: src/xcfr_checker.sv
`default_nettype none
module xcfr_checker
  import xcfr_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [STATUS_W-1:0] out_status,
  input wire logic [BYTE_W-1:0]   out_data_byte,
  input wire logic [INDEX_W-1:0]  out_byte_index,
  input wire logic                out_last
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_data_byte) && $stable(out_byte_index) && $stable(out_last))
    else $error("result changed while stalled");

  // Error statuses are single, zeroed results.
  a_status_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_GOOD |->
      out_last && out_data_byte == '0 && out_byte_index == '0)
    else $error("malformed status result");

  // A payload run streams without gaps and with rising indexes.
  a_run_next: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_status == ST_GOOD && !out_last |=>
      out_valid && out_status == ST_GOOD &&
      out_byte_index == $past(out_byte_index) + INDEX_W'(1))
    else $error("payload run broken");

  // No result right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule

bind xor_checked_frame_receiver xcfr_checker u_xcfr_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_status    (out_status),
  .out_data_byte (out_data_byte),
  .out_byte_index(out_byte_index),
  .out_last      (out_last)
);
`default_nettype wire
